@@ hw/rtl/point_proximity_pruner_top_defines.svh @@
// assertion macros for the point proximity pruner rtl
// included by modules that carry concurrent checks; no other dependencies
`ifndef POINT_PROXIMITY_PRUNER_TOP_DEFINES_SVH
`define POINT_PROXIMITY_PRUNER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppp check failed");
`define PPP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ppp check failed");
`else
`define PPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PPP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/ppp_pkg.sv @@
// shared types and codes for the point proximity pruner
// used by ppp_mem, ppp_dist, ppp_ctrl and the top level; no dependencies
`default_nettype none

package ppp_pkg;

  // action codes of an input beat
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_PRUNE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_LIMIT  = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_ACTIVE = 2'd2;

  localparam int        PADDR_W        = 5;
  localparam int        PDATA_W        = 64;
  localparam int        LIMIT_W        = 33;
  localparam int        CNT_W          = 7;
  localparam logic [CNT_W-1:0] ACTIVE_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        live;
    logic [7:0]  fail_iters;
  } in_item_t;

  typedef struct packed {
    logic [5:0]       out_slot;
    logic [15:0]      out_x;
    logic [15:0]      out_y;
    logic             out_live;
    logic [7:0]       out_fail;
    logic [CNT_W-1:0] live_total;
  } out_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } pos_t;

  typedef struct packed {
    logic       live;
    logic [7:0] fail;
  } meta_t;

  typedef struct packed {
    logic rd_en;
    logic pos_we;
    logic meta_we;
  } mem_ctl_t;

  typedef struct packed {
    logic issue;
    logic flush;
  } dist_ctl_t;

  typedef struct packed {
    logic       vld;
    logic       close;
    logic       live;
    logic [7:0] fail;
  } pair_res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_UPD,
    ST_RD_RD,
    ST_PR_PASS,
    ST_PR_RD_I,
    ST_PR_LAT_I,
    ST_PR_SCAN,
    ST_RESULT
  } ctrl_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/point_proximity_pruner_top.sv @@
// point proximity pruner: a table of tracked points with greedy distance pruning
// top level holds the configuration registers; uses ppp_pkg, ppp_mem, ppp_dist, ppp_ctrl
//
// Usage:
//   in channel (in_valid / in_stall / in_data) takes one command beat at a time:
//   write entry, run prune or read entry. out channel (out_valid / out_stall /
//   out_data) gives one beat for each read and each prune, none for a write.
//   Configuration registers sit on the APB-style port at byte addresses 0
//   (squared distance limit), 8 (count limit) and 16 (active entries).
//   A prune runs up to two passes, each only if the live count exceeds the
//   count limit at its start. The scan reads one earlier entry per cycle,
//   while the scanned entry stays live, from the single read port and pushes
//   it down a three stage distance pipeline; each new entry waits for that
//   pipeline to drain.
//   After reset the live/fail memory is swept to zero with in_stall high;
//   configuration writes are taken during the sweep.
//   A finished result sits in the output register while the next command is
//   accepted; a further result waits until out_stall drops.
`default_nettype none

module point_proximity_pruner_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  ppp_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output ppp_pkg::out_item_t                 out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ppp_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ppp_pkg::PDATA_W-1:0]   pwdata,
  output logic [ppp_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import ppp_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   cnt_lim_r;
  logic [CNT_W-1:0]   active_r;
  logic               cfg_wr;
  logic [1:0]         reg_idx;

  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] rd_addr, wr_addr, issue_idx, ev_idx;
  pos_t             wr_pos, rd_pos, i_pos;
  meta_t            wr_meta, rd_meta;
  dist_ctl_t        dctl;
  pair_res_t        ev;
  logic             dist_idle;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= '0;
      cnt_lim_r <= '0;
      active_r  <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LIMIT:  limit_r   <= pwdata[LIMIT_W-1:0];
        REG_COUNT:  cnt_lim_r <= pwdata[CNT_W-1:0];
        REG_ACTIVE: active_r  <= pwdata[CNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LIMIT:  prdata = PDATA_W'(limit_r);
      REG_COUNT:  prdata = PDATA_W'(cnt_lim_r);
      REG_ACTIVE: prdata = PDATA_W'(active_r);
      default:    prdata = '0;
    endcase
  end

  ppp_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_pos  (wr_pos),
    .wr_meta (wr_meta),
    .rd_pos  (rd_pos),
    .rd_meta (rd_meta)
  );

  ppp_dist #(.TABLE_DEPTH(TABLE_DEPTH)) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .dctl      (dctl),
    .issue_idx (issue_idx),
    .i_pos     (i_pos),
    .j_pos     (rd_pos),
    .j_meta    (rd_meta),
    .limit     (limit_r),
    .ev        (ev),
    .ev_idx    (ev_idx),
    .idle      (dist_idle)
  );

  ppp_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .count_limit    (cnt_lim_r),
    .active_entries (active_r),
    .mem_ctl        (mem_ctl),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .wr_pos         (wr_pos),
    .wr_meta        (wr_meta),
    .rd_pos         (rd_pos),
    .rd_meta        (rd_meta),
    .dctl           (dctl),
    .issue_idx      (issue_idx),
    .i_pos          (i_pos),
    .ev             (ev),
    .ev_idx         (ev_idx),
    .dist_idle      (dist_idle)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ppp_mem.sv @@
// entry storage: position memory and live/fail memory, one read port each
// with registered read data and one write port; uses ppp_pkg
`default_nettype none

module ppp_mem #(
  parameter int TABLE_DEPTH = 64,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic              clk,
  input  ppp_pkg::mem_ctl_t      mem_ctl,
  input  wire logic [IDX_W-1:0]  rd_addr,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  ppp_pkg::pos_t          wr_pos,
  input  ppp_pkg::meta_t         wr_meta,
  output ppp_pkg::pos_t          rd_pos,
  output ppp_pkg::meta_t         rd_meta
);
  import ppp_pkg::*;

  pos_t  pos_mem  [TABLE_DEPTH];
  meta_t meta_mem [TABLE_DEPTH];
  pos_t  rd_pos_r;
  meta_t rd_meta_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_pos_r  <= pos_mem[rd_addr];
      rd_meta_r <= meta_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.pos_we) begin
      pos_mem[wr_addr] <= wr_pos;
    end
    if (mem_ctl.meta_we) begin
      meta_mem[wr_addr] <= wr_meta;
    end
  end

  assign rd_pos  = rd_pos_r;
  assign rd_meta = rd_meta_r;

endmodule

`default_nettype wire

@@ hw/rtl/ppp_dist.sv @@
// pair distance pipeline: abs difference, squares, sum and compare
// one pair enters per cycle, flush drops all pairs in flight; uses ppp_pkg
`default_nettype none

module ppp_dist #(
  parameter int TABLE_DEPTH = 64,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  ppp_pkg::dist_ctl_t               dctl,
  input  wire logic [IDX_W-1:0]             issue_idx,
  input  ppp_pkg::pos_t                     i_pos,
  input  ppp_pkg::pos_t                     j_pos,
  input  ppp_pkg::meta_t                    j_meta,
  input  wire logic [ppp_pkg::LIMIT_W-1:0]  limit,
  output ppp_pkg::pair_res_t                ev,
  output logic [IDX_W-1:0]                  ev_idx,
  output logic                              idle
);
  import ppp_pkg::*;

  logic             v1_r, v2_r, v3_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r;
  logic [15:0]      dx_r, dy_r;
  logic             live2_r, live3_r;
  logic [7:0]       fail2_r, fail3_r;
  logic [31:0]      sqx_r, sqy_r;
  logic [15:0]      dx, dy;
  logic [LIMIT_W-1:0] dist_sq;

  // stage one lines up with the memory read data
  assign dx = (i_pos.x >= j_pos.x) ? (i_pos.x - j_pos.x) : (j_pos.x - i_pos.x);
  assign dy = (i_pos.y >= j_pos.y) ? (i_pos.y - j_pos.y) : (j_pos.y - i_pos.y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= dctl.issue & ~dctl.flush;
      v2_r <= v1_r & ~dctl.flush;
      v3_r <= v2_r & ~dctl.flush;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r  <= issue_idx;
    idx2_r  <= idx1_r;
    dx_r    <= dx;
    dy_r    <= dy;
    live2_r <= j_meta.live;
    fail2_r <= j_meta.fail;
    idx3_r  <= idx2_r;
    sqx_r   <= 32'(dx_r) * 32'(dx_r);
    sqy_r   <= 32'(dy_r) * 32'(dy_r);
    live3_r <= live2_r;
    fail3_r <= fail2_r;
  end

  assign dist_sq  = LIMIT_W'(sqx_r) + LIMIT_W'(sqy_r);
  assign ev.vld   = v3_r;
  assign ev.close = dist_sq < limit;
  assign ev.live  = live3_r;
  assign ev.fail  = fail3_r;
  assign ev_idx   = idx3_r;
  assign idle     = ~(v1_r | v2_r | v3_r);

endmodule

`default_nettype wire

@@ hw/rtl/ppp_ctrl.sv @@
// sequencer: clear sweep, entry write and read, the two prune passes,
// live counter and the result register; uses ppp_pkg and the assertion macros
`default_nettype none
`include "point_proximity_pruner_top_defines.svh"

module ppp_ctrl #(
  parameter int TABLE_DEPTH = 64,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  ppp_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output ppp_pkg::out_item_t               out_data,
  input  wire logic [ppp_pkg::CNT_W-1:0]   count_limit,
  input  wire logic [ppp_pkg::CNT_W-1:0]   active_entries,
  output ppp_pkg::mem_ctl_t                mem_ctl,
  output logic [IDX_W-1:0]                 rd_addr,
  output logic [IDX_W-1:0]                 wr_addr,
  output ppp_pkg::pos_t                    wr_pos,
  output ppp_pkg::meta_t                   wr_meta,
  input  ppp_pkg::pos_t                    rd_pos,
  input  ppp_pkg::meta_t                   rd_meta,
  output ppp_pkg::dist_ctl_t               dctl,
  output logic [IDX_W-1:0]                 issue_idx,
  output ppp_pkg::pos_t                    i_pos,
  input  ppp_pkg::pair_res_t               ev,
  input  wire logic [IDX_W-1:0]            ev_idx,
  input  wire logic                        dist_idle
);
  import ppp_pkg::*;

  localparam int SLOT_CMP_W = ((IDX_W > 6) ? IDX_W : 6) + 1;
  localparam int SCAN_W     = ((IDX_W + 1) > CNT_W) ? (IDX_W + 1) : CNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  ctrl_state_t      state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  logic             pass_r, pass_nxt;
  logic [IDX_W:0]   i_r, i_nxt;
  logic [IDX_W:0]   j_r, j_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  pos_t             ipos_r, ipos_nxt;
  logic [7:0]       ifail_r, ifail_nxt;
  logic             out_vld_r, out_vld_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             slot_ok;
  logic [IDX_W-1:0] slot_addr;
  logic [SCAN_W-1:0] n_sat;
  logic [IDX_W:0]   n_cnt;
  logic             hit, drop_i, drop_j, is_read;
  out_item_t        res;

  assign slot_ok   = SLOT_CMP_W'(item_r.slot) < SLOT_CMP_W'(TABLE_DEPTH);
  assign slot_addr = IDX_W'(item_r.slot);
  assign n_sat     = (SCAN_W'(active_entries) > SCAN_W'(TABLE_DEPTH)) ?
                     SCAN_W'(TABLE_DEPTH) : SCAN_W'(active_entries);
  assign n_cnt     = (IDX_W + 1)'(n_sat);

  // pass one drops the entry with more failures (i on a tie), pass two drops i
  assign hit    = ev.vld && ev.live && ev.close && (state_r == ST_PR_SCAN);
  assign drop_i = hit && (pass_r || (ifail_r >= ev.fail));
  assign drop_j = hit && !drop_i;

  assign is_read = item_r.action == ACT_READ;

  always_comb begin
    res            = '0;
    res.live_total = cnt_r;
    if (is_read) begin
      res.out_slot = item_r.slot;
      if (slot_ok) begin
        res.out_x    = rd_pos.x;
        res.out_y    = rd_pos.y;
        res.out_live = rd_meta.live;
        res.out_fail = rd_meta.fail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      pass_r    <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      clr_r     <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pass_r    <= pass_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      clr_r     <= clr_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    ipos_r     <= ipos_nxt;
    ifail_r    <= ifail_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    pass_nxt     = pass_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    clr_nxt      = clr_r;
    cnt_nxt      = cnt_r;
    ipos_nxt     = ipos_r;
    ifail_nxt    = ifail_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_data_nxt = out_data_r;
    in_stall     = 1'b1;
    mem_ctl      = '0;
    rd_addr      = slot_addr;
    wr_addr      = slot_addr;
    wr_pos       = '{x: item_r.pos_x, y: item_r.pos_y};
    wr_meta      = '{live: item_r.live, fail: item_r.fail_iters};
    dctl         = '0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_ctl.meta_we = 1'b1;
        wr_addr         = clr_r;
        wr_meta         = '0;
        clr_nxt         = clr_r + IDX_W'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_nxt = in_data;
          unique case (in_data.action)
            ACT_WRITE: state_nxt = ST_WR_RD;
            ACT_PRUNE: begin
              pass_nxt  = 1'b0;
              state_nxt = ST_PR_PASS;
            end
            ACT_READ:  state_nxt = ST_RD_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WR_RD: begin
        // fetch the old live mark for the counter
        if (slot_ok) begin
          mem_ctl.rd_en = 1'b1;
          state_nxt     = ST_WR_UPD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WR_UPD: begin
        mem_ctl.pos_we  = 1'b1;
        mem_ctl.meta_we = 1'b1;
        if (item_r.live && !rd_meta.live) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (!item_r.live && rd_meta.live) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_RD_RD: begin
        mem_ctl.rd_en = slot_ok;
        state_nxt     = ST_RESULT;
      end
      ST_PR_PASS: begin
        if (cnt_r > count_limit) begin
          i_nxt     = '0;
          state_nxt = ST_PR_RD_I;
        end else if (!pass_r) begin
          pass_nxt = 1'b1;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_PR_RD_I: begin
        if (i_r >= n_cnt) begin
          if (!pass_r) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_PR_PASS;
          end else begin
            state_nxt = ST_RESULT;
          end
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = i_r[IDX_W-1:0];
          state_nxt     = ST_PR_LAT_I;
        end
      end
      ST_PR_LAT_I: begin
        ipos_nxt  = rd_pos;
        ifail_nxt = rd_meta.fail;
        j_nxt     = '0;
        if (rd_meta.live && (i_r != '0)) begin
          state_nxt = ST_PR_SCAN;
        end else begin
          i_nxt     = i_r + (IDX_W + 1)'(1);
          state_nxt = ST_PR_RD_I;
        end
      end
      ST_PR_SCAN: begin
        dctl.issue    = (j_r < i_r) && !drop_i;
        mem_ctl.rd_en = dctl.issue;
        rd_addr       = j_r[IDX_W-1:0];
        if (dctl.issue) begin
          j_nxt = j_r + (IDX_W + 1)'(1);
        end
        if (drop_i) begin
          // i is gone: its pair loop ends, pairs in flight are discarded
          mem_ctl.meta_we = 1'b1;
          wr_addr         = i_r[IDX_W-1:0];
          wr_meta         = '0;
          cnt_nxt         = cnt_r - CNT_W'(1);
          dctl.flush      = 1'b1;
          i_nxt           = i_r + (IDX_W + 1)'(1);
          state_nxt       = ST_PR_RD_I;
        end else begin
          if (drop_j) begin
            mem_ctl.meta_we = 1'b1;
            wr_addr         = ev_idx;
            wr_meta         = '0;
            cnt_nxt         = cnt_r - CNT_W'(1);
          end
          if ((j_r == i_r) && dist_idle) begin
            i_nxt     = i_r + (IDX_W + 1)'(1);
            state_nxt = ST_PR_RD_I;
          end
        end
      end
      ST_RESULT: begin
        if (!out_vld_r || !out_stall) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = res;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign issue_idx = j_r[IDX_W-1:0];
  assign i_pos     = ipos_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  `PPP_ASSERT_NEVER(a_rw_same_entry, clk, rst_n, mem_ctl.rd_en && (mem_ctl.pos_we || mem_ctl.meta_we) && (rd_addr == wr_addr))
  `PPP_ASSERT_IMP(a_idle_before_next_i, clk, rst_n, state_r == ST_PR_RD_I, dist_idle)
  `PPP_ASSERT_IMP(a_ev_only_in_scan, clk, rst_n, ev.vld, state_r == ST_PR_SCAN)
  `PPP_ASSERT_IMP(a_cnt_single_step, clk, rst_n, $past(rst_n) && (cnt_r != $past(cnt_r)), (cnt_r == $past(cnt_r) + 7'd1) || (cnt_r == $past(cnt_r) - 7'd1))

endmodule

`default_nettype wire

@@ tb/point_proximity_pruner_top_tb.sv @@
// self-checking testbench for point_proximity_pruner_top: table writes, reads and prunes
// checked beat by beat against an in-bench model of the table; depends on ppp_pkg and the rtl
module point_proximity_pruner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppp_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         DEPTH      = 64;
  localparam int         MAX_CYCLES = 2_000_000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  point_proximity_pruner_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model of the point table and its registers
  logic [15:0]     pt_x    [DEPTH];
  logic [15:0]     pt_y    [DEPTH];
  bit              pt_live [DEPTH];
  logic [7:0]      pt_fail [DEPTH];
  logic [CNT_W-1:0] live_cnt;
  logic [LIMIT_W-1:0] dist_limit;
  logic [CNT_W-1:0] count_lim;
  logic [CNT_W-1:0] active_n;

  in_item_t  cmd_q[$];
  out_item_t pending_results[$];
  bit        seen_slot [DEPTH];
  int        seen_count;
  bit        no_gaps;
  int        errors;
  int        cycles;
  int        n_writes, n_reads, n_prunes, n_ignored, n_settings;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic bit is_near(int a, int b);
    logic [15:0] dx, dy;
    logic [33:0] d2;
    dx = (pt_x[a] >= pt_x[b]) ? pt_x[a] - pt_x[b] : pt_x[b] - pt_x[a];
    dy = (pt_y[a] >= pt_y[b]) ? pt_y[a] - pt_y[b] : pt_y[b] - pt_y[a];
    d2 = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
    return d2 < {1'b0, dist_limit};
  endfunction

  function automatic void drop_point(int k);
    pt_live[k] = 1'b0;
    pt_fail[k] = '0;
    live_cnt = live_cnt - 1'b1;
  endfunction

  // pass one keeps the entry with fewer failures, pass two drops the later of a close pair
  function automatic void prune_table();
    int n;
    n = (active_n > DEPTH) ? DEPTH : int'(active_n);
    if (live_cnt > count_lim) begin
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < i && pt_live[i]; j++) begin
          if (pt_live[j] && is_near(i, j)) begin
            if (pt_fail[i] >= pt_fail[j]) drop_point(i);
            else drop_point(j);
          end
        end
      end
    end
    if (live_cnt > count_lim) begin
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < i && pt_live[i]; j++) begin
          if (pt_live[j] && is_near(i, j)) drop_point(i);
        end
      end
    end
  endfunction

  function automatic void apply_cmd(in_item_t c);
    out_item_t r;
    r = '0;
    case (c.action)
      ACT_WRITE: begin
        if (c.live && !pt_live[c.slot]) live_cnt = live_cnt + 1'b1;
        else if (!c.live && pt_live[c.slot]) live_cnt = live_cnt - 1'b1;
        pt_x[c.slot]    = c.pos_x;
        pt_y[c.slot]    = c.pos_y;
        pt_live[c.slot] = c.live;
        pt_fail[c.slot] = c.fail_iters;
        n_writes++;
      end
      ACT_PRUNE: begin
        prune_table();
        r.live_total = live_cnt;
        pending_results.push_back(r);
        n_prunes++;
      end
      ACT_READ: begin
        r.out_slot   = c.slot;
        r.out_x      = pt_x[c.slot];
        r.out_y      = pt_y[c.slot];
        r.out_live   = pt_live[c.slot];
        r.out_fail   = pt_fail[c.slot];
        r.live_total = live_cnt;
        pending_results.push_back(r);
        n_reads++;
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // driver: one beat at a time from cmd_q, random gaps between beats unless no_gaps is set
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) apply_cmd(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          in_data  <= cmd_q.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!no_gaps && $urandom_range(99) < 30) stall_left = pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 64'(out_data), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_slot != want.out_slot)
          report_mismatch("out_slot", out_data.out_slot, want.out_slot);
        if (out_data.out_x != want.out_x)
          report_mismatch("out_x", out_data.out_x, want.out_x);
        if (out_data.out_y != want.out_y)
          report_mismatch("out_y", out_data.out_y, want.out_y);
        if (out_data.out_live != want.out_live)
          report_mismatch("out_live", out_data.out_live, want.out_live);
        if (out_data.out_fail != want.out_fail)
          report_mismatch("out_fail", out_data.out_fail, want.out_fail);
        if (out_data.live_total != want.live_total)
          report_mismatch("live_total", out_data.live_total, want.live_total);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic set_reg(input logic [1:0] idx, input logic [63:0] value);
    logic [63:0] mask;
    mask = (idx == REG_LIMIT) ? 64'h1_FFFF_FFFF : 64'h7F;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LIMIT: dist_limit = value[LIMIT_W-1:0];
      REG_COUNT: count_lim  = value[CNT_W-1:0];
      default:   active_n   = value[CNT_W-1:0];
    endcase
    // read it back in the same transfer sequence
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) != (value & mask))
      report_mismatch("register readback", prdata & mask, value & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_settings(input logic [32:0] lim, input logic [6:0] cnt,
                               input logic [6:0] act);
    set_reg(REG_LIMIT, 64'(lim));
    set_reg(REG_COUNT, 64'(cnt));
    set_reg(REG_ACTIVE, 64'(act));
    n_settings++;
  endtask

  // block is idle once nothing is queued, nothing is offered and no result is owed;
  // a trailing write may still be in the pipe, so the task waits on past that point
  task automatic wait_quiet();
    while (cmd_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic queue_item(input logic [1:0] act, input logic [5:0] s,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic lv, input logic [7:0] f);
    in_item_t c;
    c.action     = act;
    c.slot       = s;
    c.pos_x      = x;
    c.pos_y      = y;
    c.live       = lv;
    c.fail_iters = f;
    cmd_q.push_back(c);
    if (act == ACT_WRITE && !seen_slot[s]) begin
      seen_slot[s] = 1'b1;
      seen_count++;
    end
  endtask

  function automatic logic [15:0] jitter(logic [15:0] c);
    return c + 16'($urandom_range(64)) - 16'd32;
  endfunction

  task automatic random_phase(input logic [32:0] lim, input logic [6:0] cnt,
                              input logic [6:0] act, input int n_items,
                              input int prune_pct, input bit steady);
    int          made;
    int          r;
    int          span;
    logic [5:0]  s;
    logic [15:0] cx, cy, x, y;
    logic [7:0]  f;
    wait_quiet();
    load_settings(lim, cnt, act);
    no_gaps = steady;
    span = (act == 0 || act > DEPTH) ? DEPTH : int'(act);
    cx = 16'($urandom);
    cy = 16'($urandom);
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(99);
      if (r < 5) begin
        queue_item(ACT_UNUSED, 6'($urandom), 16'($urandom), 16'($urandom),
                   1'($urandom), 8'($urandom));
      end else begin
        made++;
        if (r < 5 + prune_pct) begin
          queue_item(ACT_PRUNE, 6'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom), 8'($urandom));
        end else if (r < 25 + prune_pct && seen_count != 0) begin
          s = 6'($urandom);
          while (!seen_slot[s]) s = s + 1'b1;
          queue_item(ACT_READ, s, 16'($urandom), 16'($urandom),
                     1'($urandom), 8'($urandom));
        end else begin
          s = ($urandom_range(99) < 10) ? 6'($urandom) : 6'($urandom_range(span - 1));
          if ($urandom_range(9) == 0) begin
            cx = 16'($urandom);
            cy = 16'($urandom);
          end
          if ($urandom_range(99) < 20) begin
            x = 16'($urandom);
            y = 16'($urandom);
          end else begin
            x = jitter(cx);
            y = jitter(cy);
          end
          if ($urandom_range(99) < 20) f = $urandom_range(1) ? 8'hFF : 8'h00;
          else f = 8'($urandom);
          queue_item(ACT_WRITE, s, x, y, $urandom_range(99) < 85, f);
        end
      end
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    out_stall = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      pt_x[k] = '0;
      pt_y[k] = '0;
      pt_live[k] = 1'b0;
      pt_fail[k] = '0;
      seen_slot[k] = 1'b0;
    end
    live_cnt   = '0;
    dist_limit = '0;
    count_lim  = '0;
    active_n   = ACTIVE_RESET;
    no_gaps    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: close pair with equal failures, close pair where the earlier one loses,
    // far corners, dead writes, a live entry going dead, ignored action code
    load_settings(33'd1024, 7'd0, 7'd64);
    queue_item(ACT_WRITE, 6'd0,  16'h0000, 16'h0000, 1'b1, 8'd5);
    queue_item(ACT_WRITE, 6'd1,  16'd10,   16'd10,   1'b1, 8'd5);
    queue_item(ACT_WRITE, 6'd2,  16'd0,    16'd20,   1'b1, 8'd2);
    queue_item(ACT_WRITE, 6'd3,  16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
    queue_item(ACT_WRITE, 6'd63, 16'hFFF0, 16'hFFFF, 1'b1, 8'h00);
    queue_item(ACT_WRITE, 6'd4,  16'h8000, 16'h0000, 1'b1, 8'h00);
    queue_item(ACT_WRITE, 6'd5,  16'h1234, 16'hABCD, 1'b0, 8'h80);
    queue_item(ACT_WRITE, 6'd4,  16'h8000, 16'h0000, 1'b0, 8'h00);
    queue_item(ACT_WRITE, 6'd6,  16'h0F0F, 16'hF0F0, 1'b1, 8'h7F);
    queue_item(ACT_READ,  6'd5,  16'h0000, 16'h0000, 1'b0, 8'h00);
    queue_item(ACT_READ,  6'd0,  16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
    queue_item(ACT_UNUSED, 6'd7, 16'h5555, 16'hAAAA, 1'b1, 8'h55);
    queue_item(ACT_PRUNE, 6'd0,  16'h0000, 16'h0000, 1'b0, 8'h00);
    queue_item(ACT_READ,  6'd0,  16'h0000, 16'h0000, 1'b0, 8'h00);
    queue_item(ACT_READ,  6'd1,  16'h0000, 16'h0000, 1'b0, 8'h00);
    queue_item(ACT_READ,  6'd2,  16'h0000, 16'h0000, 1'b0, 8'h00);
    queue_item(ACT_READ,  6'd3,  16'h0000, 16'h0000, 1'b0, 8'h00);
    queue_item(ACT_READ,  6'd63, 16'h0000, 16'h0000, 1'b0, 8'h00);
    queue_item(ACT_READ,  6'd6,  16'h0000, 16'h0000, 1'b0, 8'h00);
    queue_item(ACT_PRUNE, 6'd63, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
    queue_item(ACT_READ,  6'd4,  16'h0000, 16'h0000, 1'b0, 8'h00);

    // random phases over a spread of register settings
    random_phase(33'd3000,        7'd0,   7'd8,   35, 20, 1'b0);
    random_phase(33'h1_FFFF_FFFF, 7'd0,   7'd16,  35, 15, 1'b1);
    random_phase(33'd0,           7'd0,   7'd64,  35, 6,  1'b0);
    random_phase(33'd6000,        7'd64,  7'd127, 35, 15, 1'b0);
    random_phase(33'd20000,       7'd3,   7'd1,   35, 15, 1'b0);
    random_phase(33'd8000,        7'd127, 7'd0,   35, 10, 1'b1);
    random_phase(33'($urandom_range(8191)), 7'($urandom_range(12)), 7'd24, 35, 15, 1'b0);
    random_phase(33'd4000,        7'd6,   7'd12,  35, 25, 1'b0);
    wait_quiet();

    $display("covered %0d writes, %0d reads, %0d prunes and %0d ignored beats",
             n_writes, n_reads, n_prunes, n_ignored);
    $display("across %0d register settings in %0d cycles, %0d mismatches",
             n_settings, cycles, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
